// ----- rtl/assert_macros.svh -----
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, a, b)
`define ASSERT_NEXT(label, clk, rst, a, b)
`endif
`endif

// ----- rtl/kabf_pkg.sv -----
package kabf_pkg;
  localparam int NumChannels = 2;
  localparam int ChWidth = (NumChannels > 1) ? $clog2(NumChannels) : 1;
  localparam int FracBits = 24;
  localparam int RegWidth = 31;
  localparam int CfgIdxWidth = 3;
  localparam int DivSteps = 32 + FracBits;

  localparam logic [CfgIdxWidth-1:0] RegQAngle = 3'd0;
  localparam logic [CfgIdxWidth-1:0] RegQBias = 3'd1;
  localparam logic [CfgIdxWidth-1:0] RegRPitch = 3'd2;
  localparam logic [CfgIdxWidth-1:0] RegRRoll = 3'd3;
  localparam logic [CfgIdxWidth-1:0] RegTimeStep = 3'd4;

  // Saturate a wide signed value to 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [65:0] hi;
    logic signed [65:0] lo;
    hi = 66'sd2147483647;
    lo = -66'sd2147483648;
    if (v > hi) begin
      sat32 = 32'sh7fffffff;
    end else if (v < lo) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction
endpackage

// ----- rtl/kalman_angle_bias_filter.sv -----
// Two-state Kalman filter (angle and gyro bias) per channel, signed Q8.24.
// A single 32x32 multiplier is used for all ten products in turn. The two
// gains come from one restoring divider. It loads its operands, then runs
// one quotient bit per cycle, and each gain has 56 quotient bits.
// s_axis_tready stays low while an item is in work. The result waits in
// the output register, and the next item is taken as soon as it is issued.
// A result that is still held downstream stalls the issue cycle.
module kalman_angle_bias_filter (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [31:0] measured_angle, [63:32] measured_rate
  input  logic [63:0] s_axis_tdata,
  // [0] channel
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [31:0] estimated_angle
  output logic [31:0] m_axis_tdata,
  input  logic        cfg_we,
  input  logic [kabf_pkg::CfgIdxWidth-1:0] cfg_index,
  input  logic [kabf_pkg::RegWidth-1:0]    cfg_data
);
  import kabf_pkg::*;
  `include "assert_macros.svh"

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_MUL  = 6'b000010,
    ST_DIV  = 6'b000100,
    ST_WAIT = 6'b001000,
    ST_WB   = 6'b010000,
    ST_OUT  = 6'b100000
  } state_t;

  state_t state;
  logic [RegWidth-1:0] q_angle, q_bias, r_pitch, r_roll, time_step;
  logic signed [31:0] ang_mem [NumChannels];
  logic signed [31:0] bia_mem [NumChannels];
  logic signed [31:0] p00_mem [NumChannels];
  logic signed [31:0] p01_mem [NumChannels];
  logic signed [31:0] p10_mem [NumChannels];
  logic signed [31:0] p11_mem [NumChannels];

  logic [ChWidth-1:0] ch;
  logic signed [31:0] z, w, ang, bia, p00, p01, p10, p11, dtp11, k0, k1, y, t00, t01;
  logic [3:0] step;

  // shared multiplier with registered product
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] prod;
  logic signed [31:0] qprod;
  assign qprod = sat32(66'(prod >>> FracBits));

  // shared restoring divider on magnitudes
  logic [DivSteps-1:0] quo;
  logic [32:0] rem;
  logic [31:0] dmag;
  logic [DivSteps-1:0] dnum;
  logic [5:0] dcnt;
  logic dneg, dzero, dsel;
  logic [33:0] rtrial;
  assign rtrial = {rem, dnum[DivSteps-1]} - {2'b0, dmag};

  logic signed [31:0] s_val;
  logic signed [31:0] k_res;
  logic signed [65:0] k_wide;
  assign s_val = sat32(66'(p00) + 66'($signed({1'b0, (ch == '0) ? r_pitch : r_roll})));
  assign k_wide = dneg ? -$signed({10'b0, quo}) : $signed({10'b0, quo});
  assign k_res = dzero ? 32'sd0 : sat32(k_wide);

  logic signed [31:0] dt;
  assign dt = $signed({1'b0, time_step});

  // multiply schedule operands
  always_comb begin
    mul_a = dt;
    mul_b = 32'sd0;
    case (step)
      4'd0: mul_b = sat32(66'(w) - 66'(bia));
      4'd1: mul_b = p11;
      4'd2: mul_b = sat32(66'(dtp11) - 66'(p01) - 66'(p10) + 66'($signed({1'b0, q_angle})));
      4'd3: mul_b = $signed({1'b0, q_bias});
      4'd4: begin mul_a = k0; mul_b = y; end
      4'd5: begin mul_a = k1; mul_b = y; end
      4'd6: begin mul_a = k0; mul_b = t00; end
      4'd7: begin mul_a = k0; mul_b = t01; end
      4'd8: begin mul_a = k1; mul_b = t00; end
      4'd9: begin mul_a = k1; mul_b = t01; end
      default: ;
    endcase
  end

  logic ph; // multiply phase: 0 issue, 1 consume
  assign s_axis_tready = (state == ST_IDLE) && !rst;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      q_angle <= 31'd16777;
      q_bias <= 31'd50332;
      r_pitch <= 31'd167772160;
      r_roll <= 31'd503316;
      time_step <= 31'd167772;
    end else if (cfg_we) begin
      case (cfg_index)
        RegQAngle: q_angle <= cfg_data;
        RegQBias: q_bias <= cfg_data;
        RegRPitch: r_pitch <= cfg_data;
        RegRRoll: r_roll <= cfg_data;
        RegTimeStep: time_step <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      m_axis_tvalid <= 1'b0;
      step <= '0;
      ph <= 1'b0;
      for (int i = 0; i < NumChannels; i++) begin
        ang_mem[i] <= '0; bia_mem[i] <= '0; p00_mem[i] <= '0;
        p01_mem[i] <= '0; p10_mem[i] <= '0; p11_mem[i] <= '0;
      end
    end else begin
      // output valid: set on issue, cleared when taken
      if (state == ST_OUT && (!m_axis_tvalid || m_axis_tready)) m_axis_tvalid <= 1'b1;
      else if (m_axis_tready) m_axis_tvalid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            ch <= ChWidth'(s_axis_tuser);
            z <= s_axis_tdata[31:0];
            w <= s_axis_tdata[63:32];
            ang <= ang_mem[ChWidth'(s_axis_tuser)];
            bia <= bia_mem[ChWidth'(s_axis_tuser)];
            p00 <= p00_mem[ChWidth'(s_axis_tuser)];
            p01 <= p01_mem[ChWidth'(s_axis_tuser)];
            p10 <= p10_mem[ChWidth'(s_axis_tuser)];
            p11 <= p11_mem[ChWidth'(s_axis_tuser)];
            step <= '0;
            ph <= 1'b0;
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          if (!ph) begin
            prod <= 64'(mul_a) * 64'(mul_b);
            ph <= 1'b1;
          end else begin
            ph <= 1'b0;
            step <= step + 4'd1;
            case (step)
              4'd0: ang <= sat32(66'(ang) + 66'(qprod));
              4'd1: dtp11 <= qprod;
              4'd2: begin
                p00 <= sat32(66'(p00) + 66'(qprod));
                p01 <= sat32(66'(p01) - 66'(dtp11));
                p10 <= sat32(66'(p10) - 66'(dtp11));
              end
              4'd3: begin
                p11 <= sat32(66'(p11) + 66'(qprod));
                dsel <= 1'b0;
                state <= ST_DIV;
                dcnt <= '0;
              end
              4'd4: ang <= sat32(66'(ang) + 66'(qprod));
              4'd5: bia <= sat32(66'(bia) + 66'(qprod));
              4'd6: p00 <= sat32(66'(t00) - 66'(qprod));
              4'd7: p01 <= sat32(66'(t01) - 66'(qprod));
              4'd8: p10 <= sat32(66'(p10) - 66'(qprod));
              4'd9: begin
                p11 <= sat32(66'(p11) - 66'(qprod));
                state <= ST_WB;
              end
              default: ;
            endcase
          end
        end
        ST_DIV: begin
          if (dcnt == '0) begin
            // load operands: numerator p00 or p10 shifted by FracBits
            dnum <= {((dsel ? p10[31] : p00[31]) ?
                     -(dsel ? p10 : p00) : (dsel ? p10 : p00)), FracBits'(0)};
            dmag <= s_val[31] ? -s_val : s_val;
            dneg <= (dsel ? p10[31] : p00[31]) ^ s_val[31];
            dzero <= (s_val == 32'sd0);
            rem <= '0;
            quo <= '0;
            dcnt <= 6'd1;
          end else begin
            if (!rtrial[33]) rem <= rtrial[32:0];
            else rem <= {rem[31:0], dnum[DivSteps-1]};
            dnum <= {dnum[DivSteps-2:0], 1'b0};
            quo <= {quo[DivSteps-2:0], ~rtrial[33]};
            if (dcnt == 6'(DivSteps)) state <= ST_WAIT;
            dcnt <= dcnt + 6'd1;
          end
        end
        ST_WAIT: begin
          dcnt <= '0;
          if (!dsel) begin
            k0 <= k_res;
            dsel <= 1'b1;
            state <= ST_DIV;
          end else begin
            k1 <= k_res;
            y <= sat32(66'(z) - 66'(ang));
            t00 <= p00;
            t01 <= p01;
            state <= ST_MUL;
          end
        end
        ST_WB: begin
          ang_mem[ch] <= ang; bia_mem[ch] <= bia; p00_mem[ch] <= p00;
          p01_mem[ch] <= p01; p10_mem[ch] <= p10; p11_mem[ch] <= p11;
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tdata <= ang;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `ASSERT_IMPLIES(a_ready_idle, clk, rst, s_axis_tready, state == ST_IDLE)
  `ASSERT_NEXT(a_accept_busy, clk, rst, s_axis_tvalid && s_axis_tready, state == ST_MUL)
  `ASSERT_NEXT(a_out_valid, clk, rst, state == ST_OUT && (!m_axis_tvalid || m_axis_tready), m_axis_tvalid)
  `ASSERT_IMPLIES(a_div_cnt, clk, rst, state == ST_DIV, dcnt <= 6'(DivSteps))
endmodule
